// ===== rtl/hnil_pkg.sv =====
// Package for the hashed name index lookup block.
// Holds shared sizes, payload structs, codes and the controller/datapath interface types.
package hnil_pkg;

  localparam int ENTRIES   = 1024;
  localparam int MAX_NAME  = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int POS_W     = $clog2(MAX_NAME);
  localparam int NAME_D    = ENTRIES * MAX_NAME;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] CMD_HDR   = 2'd0;
  localparam logic [1:0] CMD_NAME  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_NONAME  = 2'd2;
  localparam logic [1:0] ST_CORRUPT = 2'd3;

  localparam logic CFG_COUNT = 1'b0;
  localparam logic CFG_SIZE  = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  entry_index;
    logic [31:0] name_hash;
    logic [47:0] entry_offset;
    logic [31:0] entry_size;
    logic [6:0]  entry_name_len;
    logic [5:0]  byte_pos;
    logic [7:0]  byte_value;
    logic        byte_valid;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] data_offset;
    logic [31:0] data_size;
    logic [9:0]  found_index;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BS_RD, S_BS_CMP, S_BK_RD, S_BK_CMP, S_FW_RD, S_FW_CMP,
    S_NM_RD, S_NM_CMP, S_RES_RD, S_RES_SUM, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic bs_init;     // lo=0, hi=count
    logic rd_mid;      // read hash at mid
    logic go_lo;       // lo = mid+1
    logic go_hi;       // hi = mid
    logic scan_init;   // scan = mid
    logic rd_prev;     // read hash at scan-1
    logic scan_dec;
    logic rd_scan;     // read hash/len at scan
    logic nm_init;     // name pos = 0
    logic nm_inc;
    logic scan_inc;
    logic sum;         // compute end compare
    logic set_miss;
    logic set_noname;
    logic set_hit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lo_lt_hi;
    logic h_lt;
    logic h_eq;
    logic scan_gt_lo;
    logic scan_lt_cnt;
    logic len_ok;      // stored len == query len, query len <= MAX_NAME, last read not scan-1
    logic nm_done;     // all bytes compared
    logic byte_eq;
  } stat_t;

endpackage

// ===== rtl/hnil_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hnil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hnil_ctrl.sv =====
// Search controller for the hashed name index lookup.
// Uses hnil_pkg; drives hnil_dp through cmd_t and reads stat_t.
module hnil_ctrl
  import hnil_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  logic   out_taken,
  input  stat_t  st,
  output cmd_t   cm,
  output logic   busy,
  output logic   out_full
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cm        = '0;
    busy      = 1'b1;
    out_full  = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cm.bs_init = 1'b1;
          state_nxt  = S_BS_RD;
        end
      end
      S_BS_RD: begin
        if (st.lo_lt_hi) begin
          cm.rd_mid = 1'b1;
          state_nxt = S_BS_CMP;
        end else begin
          cm.set_miss = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_BS_CMP: begin
        if (st.h_eq) begin
          cm.scan_init = 1'b1;
          state_nxt    = S_BK_RD;
        end else if (st.h_lt) begin
          cm.go_lo  = 1'b1;
          state_nxt = S_BS_RD;
        end else begin
          cm.go_hi  = 1'b1;
          state_nxt = S_BS_RD;
        end
      end
      S_BK_RD: begin
        if (st.scan_gt_lo) begin
          cm.rd_prev = 1'b1;
          state_nxt  = S_BK_CMP;
        end else begin
          state_nxt = S_FW_RD;
        end
      end
      S_BK_CMP: begin
        if (st.h_eq) begin
          cm.scan_dec = 1'b1;
          state_nxt   = S_BK_RD;
        end else begin
          state_nxt = S_FW_RD;
        end
      end
      S_FW_RD: begin
        if (st.scan_lt_cnt) begin
          cm.rd_scan = 1'b1;
          state_nxt  = S_FW_CMP;
        end else begin
          cm.set_noname = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_FW_CMP: begin
        if (!st.h_eq) begin
          cm.set_noname = 1'b1;
          state_nxt     = S_OUT;
        end else if (st.len_ok) begin
          cm.nm_init = 1'b1;
          state_nxt  = S_NM_RD;
        end else begin
          cm.scan_inc = 1'b1;
          state_nxt   = S_FW_RD;
        end
      end
      S_NM_RD: begin
        if (st.nm_done) begin
          state_nxt = S_RES_RD;
        end else begin
          state_nxt = S_NM_CMP;
        end
      end
      S_NM_CMP: begin
        if (st.byte_eq) begin
          cm.nm_inc = 1'b1;
          state_nxt = S_NM_RD;
        end else begin
          cm.scan_inc = 1'b1;
          state_nxt   = S_FW_RD;
        end
      end
      S_RES_RD: begin
        cm.sum    = 1'b1;
        state_nxt = S_RES_SUM;
      end
      S_RES_SUM: begin
        cm.set_hit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_full = 1'b1;
        if (out_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/hnil_dp.sv =====
// Datapath: index tables, query hash/buffer, search registers, result register.
// Uses hnil_pkg and hnil_ram; commanded by hnil_ctrl.
module hnil_dp
  import hnil_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_acc,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [47:0]      cfg_data,
  input  cmd_t             cm,
  output stat_t            st,
  output out_item_t        res
);

  logic [CNT_W-1:0]   count_r;
  logic [47:0]        arch_r;
  logic [31:0]        qhash_r;
  logic [15:0]        qlen_r;
  logic [CNT_W-1:0]   lo_r, hi_r, scan_r, mid_r;
  logic [POS_W:0]     pos_r;
  logic [48:0]        end_r;
  logic               cmp_prev_r; // last hash read was scan-1
  out_item_t          res_r;

  logic [31:0]        hash_q, size_q, hash_nxt;
  logic [47:0]        off_q;
  logic [6:0]         len_q;
  logic [7:0]         name_q, qbuf_q;
  logic [IDX_W-1:0]   hash_ra;
  logic [POS_W-1:0]   qbuf_ra;
  logic [CNT_W-1:0]   mid_c, cnt_sat;
  logic               hdr_we, name_we, q_byte, qbuf_we;

  // table writes
  assign hdr_we  = in_acc && in_item.cmd == CMD_HDR;
  assign name_we = in_acc && in_item.cmd == CMD_NAME;
  assign q_byte  = in_acc && in_item.cmd == CMD_QUERY && in_item.byte_valid;
  assign qbuf_we = q_byte && qlen_r < 16'(MAX_NAME);

  assign cnt_sat = (count_r > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : count_r;
  assign mid_c   = lo_r + ((hi_r - lo_r) >> 1);

  // hash read address
  always_comb begin
    hash_ra = scan_r[IDX_W-1:0];
    if (cm.rd_mid) begin
      hash_ra = mid_c[IDX_W-1:0];
    end else if (cm.rd_prev) begin
      hash_ra = IDX_W'(scan_r - 1'b1);
    end
  end

  hnil_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_hash (
    .clk, .we(hdr_we), .waddr(in_item.entry_index), .wdata(in_item.name_hash),
    .raddr(hash_ra), .rdata(hash_q));
  hnil_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_off (
    .clk, .we(hdr_we), .waddr(in_item.entry_index), .wdata(in_item.entry_offset),
    .raddr(scan_r[IDX_W-1:0]), .rdata(off_q));
  hnil_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_size (
    .clk, .we(hdr_we), .waddr(in_item.entry_index), .wdata(in_item.entry_size),
    .raddr(scan_r[IDX_W-1:0]), .rdata(size_q));
  hnil_ram #(.WIDTH(7), .DEPTH(ENTRIES)) u_len (
    .clk, .we(hdr_we), .waddr(in_item.entry_index), .wdata(in_item.entry_name_len),
    .raddr(scan_r[IDX_W-1:0]), .rdata(len_q));
  hnil_ram #(.WIDTH(8), .DEPTH(NAME_D)) u_name (
    .clk, .we(name_we), .waddr({in_item.entry_index, in_item.byte_pos}),
    .wdata(in_item.byte_value),
    .raddr({scan_r[IDX_W-1:0], pos_r[POS_W-1:0]}), .rdata(name_q));

  assign qbuf_ra = pos_r[POS_W-1:0];
  hnil_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_qbuf (
    .clk, .we(qbuf_we), .waddr(qlen_r[POS_W-1:0]), .wdata(in_item.byte_value),
    .raddr(qbuf_ra), .rdata(qbuf_q));

  assign hash_nxt = (qhash_r ^ {24'd0, in_item.byte_value}) * FNV_PRIME;

  // config, query accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      arch_r  <= '0;
      qhash_r <= FNV_BASIS;
      qlen_r  <= '0;
    end else begin
      if (cfg_we && cfg_idx == CFG_COUNT) count_r <= cfg_data[CNT_W-1:0];
      if (cfg_we && cfg_idx == CFG_SIZE)  arch_r  <= cfg_data;
      if (q_byte) begin
        qhash_r <= hash_nxt;
        if (qlen_r != 16'hFFFF) qlen_r <= qlen_r + 16'd1;
      end
      // reset after the search is done with them
      if (cm.set_miss || cm.set_noname || cm.set_hit) begin
        qhash_r <= FNV_BASIS;
        qlen_r  <= '0;
      end
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (cm.bs_init) begin
      lo_r <= '0;
      hi_r <= cnt_sat;
    end
    if (cm.rd_mid)    mid_r <= mid_c;
    if (cm.go_lo)     lo_r  <= mid_r + 1'b1;
    if (cm.go_hi)     hi_r  <= mid_r;
    if (cm.scan_init) scan_r <= mid_r;
    if (cm.scan_dec)  scan_r <= scan_r - 1'b1;
    if (cm.scan_inc)  scan_r <= scan_r + 1'b1;
    if (cm.nm_init)   pos_r <= '0;
    if (cm.nm_inc)    pos_r <= pos_r + 1'b1;
    if (cm.sum)       end_r <= {1'b0, off_q} + {17'd0, size_q};
    if (cm.rd_mid || cm.rd_prev || cm.rd_scan) cmp_prev_r <= cm.rd_prev;
    if (cm.set_miss || cm.set_noname) begin
      res_r.status      <= cm.set_miss ? ST_MISS : ST_NONAME;
      res_r.data_offset <= '0;
      res_r.data_size   <= '0;
      res_r.found_index <= '0;
    end
    if (cm.set_hit) begin
      res_r.data_size   <= size_q;
      res_r.found_index <= scan_r[IDX_W-1:0];
      if (end_r > {1'b0, arch_r}) begin
        res_r.status      <= ST_CORRUPT;
        res_r.data_offset <= '0;
      end else begin
        res_r.status      <= ST_FOUND;
        res_r.data_offset <= off_q;
      end
    end
  end

  assign st.lo_lt_hi    = lo_r < hi_r;
  assign st.h_lt        = hash_q < qhash_r;
  assign st.h_eq        = hash_q == qhash_r;
  assign st.scan_gt_lo  = scan_r > lo_r;
  assign st.scan_lt_cnt = scan_r < cnt_sat;
  assign st.len_ok      = {9'd0, len_q} == qlen_r && qlen_r <= 16'(MAX_NAME)
                          && !cmp_prev_r;
  assign st.nm_done     = {9'd0, pos_r} == qlen_r;
  assign st.byte_eq     = name_q == qbuf_q;
  assign res            = res_r;

endmodule

// ===== rtl/hashed_name_index_lookup.sv =====
// Top level of the hashed name index lookup block.
// Uses hnil_pkg; instantiates hnil_ctrl and hnil_dp.
//
// Usage: load commands (header, name byte) and query bytes enter on the in_
// channel and are taken one per cycle while no search runs. A query item with
// last set starts a search; the block then holds in_ready low until the one
// result item on the out_ channel is taken. Load items and non-final query
// bytes produce no result.
// Search sequence: binary search steps (one hash read port, about
// log2(entry_count)+1 steps), then backward scan steps, then forward entries
// checked with their name bytes compared, then the result is formed.
// Each step waits on the registered read of the table memories.
// The result stays in its register until out_ready; a stalled receiver holds
// the block busy. Configuration writes on cfg_ take effect the next cycle.
// Reset (rst_n low, synchronous) clears the query hash and length, the config
// registers and the controller; table memories hold whatever was written.
module hashed_name_index_lookup
  import hnil_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [47:0] cfg_wdata
);

  cmd_t  cm;
  stat_t st;
  logic  busy, in_acc, start;

  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && in_data.cmd == CMD_QUERY && in_data.last;

  hnil_ctrl u_ctrl (
    .clk, .rst_n, .start, .out_taken(out_ready), .st, .cm, .busy,
    .out_full(out_valid));

  hnil_dp u_dp (
    .clk, .rst_n, .in_acc, .in_item(in_data), .cfg_we, .cfg_idx(cfg_index),
    .cfg_data(cfg_wdata), .cm, .st, .res(out_data));

endmodule

// ===== rtl/hnil_chk.sv =====
// Port-level checker for hashed_name_index_lookup, bound to the top level.
// Uses hnil_pkg.
module hnil_chk
  import hnil_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // no input taken while a result waits
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // a final query item makes the block busy
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == CMD_QUERY && in_data.last |=> !in_ready)
    else $error("search did not start");

  // miss carries zero fields
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_MISS |->
      out_data.data_offset == '0 && out_data.data_size == '0)
    else $error("miss with nonzero fields");

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind hashed_name_index_lookup hnil_chk u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data);
